/* rtl/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // how the result point is chosen
   localparam logic [1:0] MODE_LINE  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_END   = 2'd2;

endpackage

/* rtl/point_segment_distance.sv */
// ----------------------------------------------------------------------------
// point_segment_distance
// Projects a 3D query point onto a segment's line (clamped to the segment when req_tuser is set), returns the
// projected point, the parameter along the segment and the distance from the query point to that point.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every clock while the output is not
// stalled. Most of the pipeline depth is in the restoring divider, one
// quotient bit per stage over COORD_WIDTH+2 stages, and the square root, one
// result bit per stage over COORD_WIDTH+3 stages. The whole pipeline holds while
// a result waits at the output and the consumer is not ready; nothing is dropped
// or repeated.
// Coordinates are signed fixed point with FRAC_BITS fraction bits; the clamp
// flag rides on req_tuser. A zero-length segment returns the start point and
// parameter 0.
module point_segment_distance #(
   parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // seg_start_x/y/z, seg_end_x/y/z, query_x/y/z, zero fill
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // clamp_ends
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // distance, proj_x, proj_y, proj_z, seg_param, zero fill
   output logic [((5*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata
);
   import psd_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int DW  = W + 1;
   localparam int PW  = 2 * W + 2;
   localparam int SW  = 2 * W + 4;
   localparam int LW  = 2 * W + 2;
   localparam int H   = W + 2;
   localparam int LP  = 2 * W + 3;
   localparam int HP  = 2 * W + 1;
   localparam int PRW = 3 * W + 3;
   localparam int MW  = (3 * W + 4 > 2 * W + F + 4) ? 3 * W + 4 : 2 * W + F + 4;
   localparam int K   = W + 2;
   localparam int RW  = LW + 2;
   localparam int OW  = W + 3;
   localparam int XW  = W + 4;
   localparam int QW  = 2 * W + 8;
   localparam int VW  = 2 * W + 6;
   localparam int N   = W + 3;
   localparam int ODW = ((5 * W + 7) / 8) * 8;

   localparam logic [W-1:0] SAT_MAX   = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SAT_MIN   = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] PARAM_ONE = (F >= W - 1) ? SAT_MAX : W'(1) << F;

   typedef struct packed {
      logic [2:0][W-1:0]  s;
      logic [2:0][W-1:0]  e;
      logic [2:0][DW-1:0] d;
      logic [2:0][DW-1:0] p;
      logic [2:0][DW-1:0] qe;
      logic               clamp;
   } st1_type;

   typedef struct packed {
      logic [2:0][W-1:0]  s;
      logic [2:0][W-1:0]  e;
      logic [2:0][DW-1:0] d;
      logic [2:0][DW-1:0] p;
      logic               clamp;
      logic [2:0][PW-1:0] dd;
      logic [2:0][PW-1:0] dp;
      logic [2:0][PW-1:0] pp;
      logic [2:0][PW-1:0] ee;
   } st2_type;

   typedef struct packed {
      logic [2:0][W-1:0]  s;
      logic [2:0][W-1:0]  e;
      logic [2:0][DW-1:0] d;
      logic [2:0][DW-1:0] p;
      logic               clamp;
      logic [SW-1:0]      dot;
      logic [SW-1:0]      len2;
      logic [SW-1:0]      np2;
      logic [SW-1:0]      ne2;
   } st3_type;

   typedef struct packed {
      logic [2:0][W-1:0]  s;
      logic [2:0][W-1:0]  e;
      logic [2:0][DW-1:0] p;
      logic [1:0]         mode;
      logic [3:0]         sgn;
      logic [2:0][LP-1:0] lo_p;
      logic [2:0][HP-1:0] hi_p;
      logic [MW-1:0]      m3;
      logic [LW-1:0]      len2;
      logic [SW-1:0]      np2;
      logic [SW-1:0]      ne2;
   } st4_type;

   typedef struct packed {
      logic [2:0][W-1:0]   s;
      logic [2:0][W-1:0]   e;
      logic [2:0][DW-1:0]  p;
      logic [1:0]          mode;
      logic [3:0]          sgn;
      logic [2:0][PRW-1:0] prod;
      logic [MW-1:0]       m3;
      logic [LW-1:0]       len2;
      logic [SW-1:0]       np2;
      logic [SW-1:0]       ne2;
   } st5_type;

   // travels alongside the divider lanes
   typedef struct packed {
      logic [2:0][W-1:0]  s;
      logic [2:0][W-1:0]  e;
      logic [2:0][DW-1:0] p;
      logic [1:0]         mode;
      logic [3:0]         sgn;
      logic [LW:0]        den2;
      logic [SW-1:0]      np2;
      logic [SW-1:0]      ne2;
   } dside_type;

   typedef struct packed {
      dside_type         sd;
      logic [3:0][MW-1:0] m;
   } st6_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [K-1:0]  quo;
      logic [K-1:0]  num;
      logic          ovf;
   } div_type;

   typedef struct packed {
      logic [2:0][W-1:0]  proj;
      logic [W-1:0]       par;
      logic [2:0][XW-1:0] v;
      logic [1:0]         mode;
      logic [SW-1:0]      np2;
      logic [SW-1:0]      ne2;
   } pp1_type;

   typedef struct packed {
      logic [2:0][W-1:0]  proj;
      logic [W-1:0]       par;
      logic [2:0][QW-1:0] vsq;
      logic [1:0]         mode;
      logic [SW-1:0]      np2;
      logic [SW-1:0]      ne2;
   } pp2_type;

   typedef struct packed {
      logic [W-1:0]      par;
      logic [2:0][W-1:0] proj;
   } sside_type;

   typedef struct packed {
      logic [N+2:0]  rem;
      logic [N-1:0]  root;
      logic [VW-1:0] val;
   } sq_type;

   typedef struct packed {
      logic [W-1:0]      par;
      logic [2:0][W-1:0] proj;
      logic [W-1:0]      distance;
   } out_type;

   function automatic logic [W-1:0] sat_w(input logic [XW-1:0] x);
      logic [W-1:0] r;
      if (x[XW-1:W-1] == {5{x[XW-1]}}) begin
         r = x[W-1:0];
      end else begin
         r = x[XW-1] ? SAT_MIN : SAT_MAX;
      end
      return r;
   endfunction

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   st1_type s1_in, s1_ff;
   st2_type s2_in, s2_ff;
   st3_type s3_in, s3_ff;
   st4_type s4_in, s4_ff;
   st5_type s5_in, s5_ff;
   st6_type s6_in, s6_ff;
   logic    s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;

   // difference vectors
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_in.s[i]  = req_tdata[i*W +: W];
         s1_in.e[i]  = req_tdata[(3+i)*W +: W];
         s1_in.d[i]  = DW'($signed(req_tdata[(3+i)*W +: W]))
                       - DW'($signed(req_tdata[i*W +: W]));
         s1_in.p[i]  = DW'($signed(req_tdata[(6+i)*W +: W]))
                       - DW'($signed(req_tdata[i*W +: W]));
         s1_in.qe[i] = DW'($signed(req_tdata[(6+i)*W +: W]))
                       - DW'($signed(req_tdata[(3+i)*W +: W]));
      end
      s1_in.clamp = req_tuser[0];
   end

   // component products
   always_comb begin
      s2_in.s     = s1_ff.s;
      s2_in.e     = s1_ff.e;
      s2_in.d     = s1_ff.d;
      s2_in.p     = s1_ff.p;
      s2_in.clamp = s1_ff.clamp;
      for (int i = 0; i < 3; i++) begin
         s2_in.dd[i] = PW'($signed(s1_ff.d[i])) * PW'($signed(s1_ff.d[i]));
         s2_in.dp[i] = PW'($signed(s1_ff.d[i])) * PW'($signed(s1_ff.p[i]));
         s2_in.pp[i] = PW'($signed(s1_ff.p[i])) * PW'($signed(s1_ff.p[i]));
         s2_in.ee[i] = PW'($signed(s1_ff.qe[i])) * PW'($signed(s1_ff.qe[i]));
      end
   end

   // dot products
   always_comb begin
      s3_in.s     = s2_ff.s;
      s3_in.e     = s2_ff.e;
      s3_in.d     = s2_ff.d;
      s3_in.p     = s2_ff.p;
      s3_in.clamp = s2_ff.clamp;
      s3_in.dot   = SW'($signed(s2_ff.dp[0])) + SW'($signed(s2_ff.dp[1]))
                    + SW'($signed(s2_ff.dp[2]));
      s3_in.len2  = SW'($signed(s2_ff.dd[0])) + SW'($signed(s2_ff.dd[1]))
                    + SW'($signed(s2_ff.dd[2]));
      s3_in.np2   = SW'($signed(s2_ff.pp[0])) + SW'($signed(s2_ff.pp[1]))
                    + SW'($signed(s2_ff.pp[2]));
      s3_in.ne2   = SW'($signed(s2_ff.ee[0])) + SW'($signed(s2_ff.ee[1]))
                    + SW'($signed(s2_ff.ee[2]));
   end

   // end-point decision, split products of |d| and |dot|
   logic [SW-1:0] dot_abs;
   logic [DW-1:0] d_mag [3];
   always_comb begin
      dot_abs = s3_ff.dot[SW-1] ? (~s3_ff.dot + SW'(1)) : s3_ff.dot;
      s4_in.s = s3_ff.s;
      s4_in.e = s3_ff.e;
      s4_in.p = s3_ff.p;
      if (s3_ff.len2 == '0 || (s3_ff.clamp && s3_ff.dot[SW-1])) begin
         s4_in.mode = MODE_START;
      end else if (s3_ff.clamp && ($signed(s3_ff.dot) > $signed(s3_ff.len2))) begin
         s4_in.mode = MODE_END;
      end else begin
         s4_in.mode = MODE_LINE;
      end
      for (int i = 0; i < 3; i++) begin
         d_mag[i]         = s3_ff.d[i][DW-1] ? (~s3_ff.d[i] + DW'(1)) : s3_ff.d[i];
         s4_in.sgn[i]     = s3_ff.d[i][DW-1] ^ s3_ff.dot[SW-1];
         s4_in.lo_p[i]    = LP'(d_mag[i]) * LP'(dot_abs[H-1:0]);
         s4_in.hi_p[i]    = HP'(d_mag[i]) * HP'(dot_abs[2*W+1:H]);
      end
      s4_in.sgn[3] = s3_ff.dot[SW-1];
      s4_in.m3     = (MW'(dot_abs) << (F + 1)) + MW'(s3_ff.len2[LW-1:0]);
      s4_in.len2   = s3_ff.len2[LW-1:0];
      s4_in.np2    = s3_ff.np2;
      s4_in.ne2    = s3_ff.ne2;
   end

   always_comb begin
      s5_in.s    = s4_ff.s;
      s5_in.e    = s4_ff.e;
      s5_in.p    = s4_ff.p;
      s5_in.mode = s4_ff.mode;
      s5_in.sgn  = s4_ff.sgn;
      for (int i = 0; i < 3; i++) begin
         s5_in.prod[i] = PRW'(s4_ff.lo_p[i]) + (PRW'(s4_ff.hi_p[i]) << H);
      end
      s5_in.m3   = s4_ff.m3;
      s5_in.len2 = s4_ff.len2;
      s5_in.np2  = s4_ff.np2;
      s5_in.ne2  = s4_ff.ne2;
   end

   // rounding numerators 2*|num| + len2 against divisor 2*len2
   always_comb begin
      s6_in.sd.s    = s5_ff.s;
      s6_in.sd.e    = s5_ff.e;
      s6_in.sd.p    = s5_ff.p;
      s6_in.sd.mode = s5_ff.mode;
      s6_in.sd.sgn  = s5_ff.sgn;
      s6_in.sd.den2 = {s5_ff.len2, 1'b0};
      s6_in.sd.np2  = s5_ff.np2;
      s6_in.sd.ne2  = s5_ff.ne2;
      for (int i = 0; i < 3; i++) begin
         s6_in.m[i] = (MW'(s5_ff.prod[i]) << 1) + MW'(s5_ff.len2);
      end
      s6_in.m[3] = s5_ff.m3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   // ---------------- divider: four lanes, one quotient bit per stage --------
   div_type   dv_in  [0:K][0:3];
   div_type   dv_ff  [0:K][0:3];
   dside_type dsd_ff [0:K];
   logic      dvld_ff [0:K];
   logic [MW-1:0] m_hi [4];

   // quotient overflow check and remainder seed
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         m_hi[l]          = s6_ff.m[l] >> K;
         dv_in[0][l].ovf  = m_hi[l] >= MW'(s6_ff.sd.den2);
         dv_in[0][l].rem  = RW'(m_hi[l]);
         dv_in[0][l].num  = s6_ff.m[l][K-1:0];
         dv_in[0][l].quo  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff[0] <= 1'b0;
      end else if (en) begin
         dvld_ff[0] <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dsd_ff[0] <= s6_ff.sd;
         for (int l = 0; l < 4; l++) begin
            dv_ff[0][l] <= dv_in[0][l];
         end
      end
   end

   for (genvar j = 0; j < K; j++) begin : g_div
      logic [RW-1:0] trial [4];

      always_comb begin
         for (int l = 0; l < 4; l++) begin
            trial[l] = {dv_ff[j][l].rem[RW-2:0], dv_ff[j][l].num[K-1]};
            dv_in[j+1][l].ovf = dv_ff[j][l].ovf;
            dv_in[j+1][l].num = dv_ff[j][l].num << 1;
            if (trial[l] >= RW'(dsd_ff[j].den2)) begin
               dv_in[j+1][l].rem = trial[l] - RW'(dsd_ff[j].den2);
               dv_in[j+1][l].quo = {dv_ff[j][l].quo[K-2:0], 1'b1};
            end else begin
               dv_in[j+1][l].rem = trial[l];
               dv_in[j+1][l].quo = {dv_ff[j][l].quo[K-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvld_ff[j+1] <= 1'b0;
         end else if (en) begin
            dvld_ff[j+1] <= dvld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dsd_ff[j+1] <= dsd_ff[j];
            for (int l = 0; l < 4; l++) begin
               dv_ff[j+1][l] <= dv_in[j+1][l];
            end
         end
      end
   end

   // ---------------- result point, parameter, residual ----------------------
   pp1_type p1_in, p1_ff;
   pp2_type p2_in, p2_ff;
   logic    p1_vld_ff, p2_vld_ff;
   logic [OW-1:0] off_mag [3];
   logic [OW-1:0] off     [3];
   logic [XW-1:0] par_s;
   logic [W-1:0]  par_line;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off_mag[i] = OW'(dv_ff[K][i].quo);
         off[i]     = dsd_ff[K].sgn[i] ? (~off_mag[i] + OW'(1)) : off_mag[i];
         p1_in.v[i] = XW'($signed(dsd_ff[K].p[i])) - XW'($signed(off[i]));
         case (dsd_ff[K].mode)
            MODE_START: p1_in.proj[i] = dsd_ff[K].s[i];
            MODE_END:   p1_in.proj[i] = dsd_ff[K].e[i];
            default:    p1_in.proj[i] = sat_w(XW'($signed(dsd_ff[K].s[i]))
                                              + XW'($signed(off[i])));
         endcase
      end
      par_s = dsd_ff[K].sgn[3] ? (~XW'(dv_ff[K][3].quo) + XW'(1)) : XW'(dv_ff[K][3].quo);
      if (dv_ff[K][3].ovf) begin
         par_line = dsd_ff[K].sgn[3] ? SAT_MIN : SAT_MAX;
      end else begin
         par_line = sat_w(par_s);
      end
      case (dsd_ff[K].mode)
         MODE_START: p1_in.par = '0;
         MODE_END:   p1_in.par = PARAM_ONE;
         default:    p1_in.par = par_line;
      endcase
      p1_in.mode = dsd_ff[K].mode;
      p1_in.np2  = dsd_ff[K].np2;
      p1_in.ne2  = dsd_ff[K].ne2;
   end

   always_comb begin
      p2_in.proj = p1_ff.proj;
      p2_in.par  = p1_ff.par;
      p2_in.mode = p1_ff.mode;
      p2_in.np2  = p1_ff.np2;
      p2_in.ne2  = p1_ff.ne2;
      for (int i = 0; i < 3; i++) begin
         p2_in.vsq[i] = QW'($signed(p1_ff.v[i])) * QW'($signed(p1_ff.v[i]));
      end
   end

   // ---------------- square root: one root bit per stage --------------------
   sq_type    sq_in  [0:N];
   sq_type    sq_ff  [0:N];
   sside_type ssd_ff [0:N];
   logic      qvld_ff [0:N];
   logic [QW+1:0] vsum;

   always_comb begin
      vsum = (QW+2)'(p2_ff.vsq[0]) + (QW+2)'(p2_ff.vsq[1]) + (QW+2)'(p2_ff.vsq[2]);
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
      case (p2_ff.mode)
         MODE_START: sq_in[0].val = VW'(p2_ff.np2);
         MODE_END:   sq_in[0].val = VW'(p2_ff.ne2);
         default:    sq_in[0].val = vsum[VW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         qvld_ff[0] <= 1'b0;
      end else if (en) begin
         p1_vld_ff  <= dvld_ff[K];
         p2_vld_ff  <= p1_vld_ff;
         qvld_ff[0] <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff       <= p1_in;
         p2_ff       <= p2_in;
         sq_ff[0]    <= sq_in[0];
         ssd_ff[0]   <= '{par: p2_ff.par, proj: p2_ff.proj};
      end
   end

   for (genvar t = 0; t < N; t++) begin : g_sqrt
      logic [N+2:0] rem_sh;
      logic [N+2:0] trial;

      always_comb begin
         rem_sh = {sq_ff[t].rem[N:0], sq_ff[t].val[VW-1 -: 2]};
         trial  = (N+3)'({sq_ff[t].root, 2'b01});
         sq_in[t+1].val = sq_ff[t].val << 2;
         if (rem_sh >= trial) begin
            sq_in[t+1].rem  = rem_sh - trial;
            sq_in[t+1].root = {sq_ff[t].root[N-2:0], 1'b1};
         end else begin
            sq_in[t+1].rem  = rem_sh;
            sq_in[t+1].root = {sq_ff[t].root[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qvld_ff[t+1] <= 1'b0;
         end else if (en) begin
            qvld_ff[t+1] <= qvld_ff[t];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[t+1]  <= sq_in[t+1];
            ssd_ff[t+1] <= ssd_ff[t];
         end
      end
   end

   // ---------------- output register ----------------------------------------
   out_type out_in, out_ff;
   logic    out_vld_ff;

   always_comb begin
      out_in.par  = ssd_ff[N].par;
      out_in.proj = ssd_ff[N].proj;
      if (|sq_ff[N].root[N-1:W]) begin
         out_in.distance = '1;
      end else begin
         out_in.distance = sq_ff[N].root[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= qvld_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = ODW'(out_ff);

endmodule
